// ===== rtl/sfla_pkg.sv =====
package sfla_pkg;

    localparam int POOL_BYTES_DEF  = 32768;
    localparam int ALIGN_BYTES_DEF = 8;
    localparam int CLASS_COUNT_DEF = 6;

    localparam int MIN_BLOCK   = 8;
    localparam int LINK_DEPTH  = 4096;
    localparam int LINK_AW     = 12;
    localparam int LINK_LSB    = 3;
    localparam int TOP_W       = 17;

    localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STS_OK        = 2'd0,
        STS_TRUNCATED = 2'd1,
        STS_EXHAUSTED = 2'd2,
        STS_FREE_IGN  = 2'd3
    } status_t;

    typedef struct packed
    {
        cmd_t        cmd;
        logic [15:0] string_length;
        logic [15:0] free_offset;
        logic [2:0]  free_class;
    } req_t;

    typedef struct packed
    {
        logic [15:0] block_offset;
        logic [2:0]  block_class;
        status_t     status;
    } rsp_t;

    typedef struct packed
    {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    function automatic logic [TOP_W-1:0] class_size(input logic [2:0] cls);
        class_size = TOP_W'(MIN_BLOCK) << cls;
    endfunction

endpackage

// ===== rtl/sfla_ctrl.sv =====
module sfla_ctrl
    import sfla_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ctrl_cmd_t ctrl
);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign req_ready   = (state_reg == ST_IDLE);
    assign ctrl.load   = req_valid && req_ready;
    assign ctrl.commit = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid   = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (ctrl.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctrl.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== rtl/sfla_datapath.sv =====
module sfla_datapath
    import sfla_pkg::*;
#(
    parameter int POOL_BYTES  = POOL_BYTES_DEF,
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF,
    parameter int CLASS_COUNT = CLASS_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_cmd_t ctrl,
    input  req_t      req,
    output rsp_t      rsp
);

    localparam int CLS_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

    logic [15:0]      link_mem [LINK_DEPTH];
    logic [15:0]      link_rd_reg;

    logic [15:0]      heads_reg  [CLASS_COUNT];
    logic [15:0]      heads_next [CLASS_COUNT];
    logic [TOP_W-1:0] top_reg;
    logic [TOP_W-1:0] top_next;

    req_t             req_reg;
    logic [2:0]       cls_reg;
    logic             trunc_reg;
    logic [15:0]      head_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [2:0]       cls_sel;
    logic             trunc_sel;
    logic [15:0]      head_sel;
    logic [TOP_W:0]   rsize [CLASS_COUNT];

    logic             free_ok;
    logic             link_we;
    logic [LINK_AW-1:0] link_wa;
    logic [15:0]      link_wd;

    for (genvar g = 0; g < CLASS_COUNT; g++)
    begin : g_rsize
        localparam int SZ = MIN_BLOCK << g;
        localparam int RS = ((SZ + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        assign rsize[g] = (TOP_W + 1)'(RS);
    end

    always_comb
    begin
        logic found;
        found   = 1'b0;
        cls_sel = 3'(CLASS_COUNT - 1);
        for (int i = 0; i < CLASS_COUNT; i++)
        begin
            if (!found && (TOP_W'(req.string_length) <= class_size(3'(i))))
            begin
                cls_sel = 3'(i);
                found   = 1'b1;
            end
        end
        trunc_sel = TOP_W'(req.string_length) > class_size(3'(CLASS_COUNT - 1));
        head_sel  = heads_reg[cls_sel[CLS_W-1:0]];
    end

    assign free_ok = (req_reg.free_offset != EMPTY_MARK)
                  && ({1'b0, req_reg.free_class} < 4'(CLASS_COUNT));

    always_comb
    begin
        heads_next = heads_reg;
        top_next   = top_reg;
        rsp_next   = rsp_reg;
        link_we    = 1'b0;
        link_wa    = req_reg.free_offset[LINK_LSB +: LINK_AW];
        link_wd    = heads_reg[req_reg.free_class[CLS_W-1:0]];
        if (ctrl.commit)
        begin
            rsp_next.block_offset = '0;
            rsp_next.block_class  = '0;
            rsp_next.status       = STS_OK;
            if (req_reg.cmd == CMD_ALLOC)
            begin
                rsp_next.block_class = cls_reg;
                if (head_reg != EMPTY_MARK)
                begin
                    heads_next[cls_reg[CLS_W-1:0]] = link_rd_reg;
                    rsp_next.block_offset = head_reg;
                    rsp_next.status = trunc_reg ? STS_TRUNCATED : STS_OK;
                end
                else if (({1'b0, top_reg} + rsize[cls_reg[CLS_W-1:0]])
                         > (TOP_W + 1)'(POOL_BYTES))
                begin
                    rsp_next.status = STS_EXHAUSTED;
                end
                else
                begin
                    rsp_next.block_offset = top_reg[15:0];
                    top_next = top_reg + class_size(cls_reg);
                    rsp_next.status = trunc_reg ? STS_TRUNCATED : STS_OK;
                end
            end
            else if (free_ok)
            begin
                link_we = 1'b1;
                heads_next[req_reg.free_class[CLS_W-1:0]] = req_reg.free_offset;
            end
            else
            begin
                rsp_next.status = STS_FREE_IGN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        if (ctrl.load)
        begin
            link_rd_reg <= link_mem[head_sel[LINK_LSB +: LINK_AW]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            req_reg   <= req;
            cls_reg   <= cls_sel;
            trunc_reg <= trunc_sel;
            head_reg  <= head_sel;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                heads_reg[i] <= EMPTY_MARK;
            end
            top_reg <= TOP_W'(ALIGN_BYTES);
        end
        else
        begin
            heads_reg <= heads_next;
            top_reg   <= top_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== rtl/segregated_free_list_allocator_unit.sv =====
// Segregated free-list allocator with CLASS_COUNT size classes of 8 << i bytes. Each request
// beat (allocate or free) produces exactly one response beat. Accepting a request selects the
// class and starts the synchronous read of the link store at the class head; the commit step,
// which waits while the previous response is stalled, then does the pop, bump or push and loads
// the response register. No new request is taken until that commit. Allocation pops the class
// list when it is not empty, otherwise carves from the top pointer and reports exhaustion
// without changing state when the pool would overflow. The link store is 4096 entries and is
// not cleared at reset; list heads reset to empty, so no stale link is ever followed.
module segregated_free_list_allocator_unit
    import sfla_pkg::*;
#(
    parameter int POOL_BYTES  = POOL_BYTES_DEF,
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF,
    parameter int CLASS_COUNT = CLASS_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    ctrl_cmd_t ctrl;

    sfla_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    sfla_datapath #(
        .POOL_BYTES  (POOL_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES),
        .CLASS_COUNT (CLASS_COUNT)
    ) u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== rtl/sfla_checker.sv =====
module sfla_checker
    import sfla_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted on consecutive cycles");

    a_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STS_FREE_IGN)
        |-> (rsp.block_offset == 16'd0) && (rsp.block_class == 3'd0))
        else $error("ignored free returned a nonzero offset or class");

    a_exhaust_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STS_EXHAUSTED) |-> (rsp.block_offset == 16'd0))
        else $error("exhausted allocation returned a nonzero offset");

endmodule

bind segregated_free_list_allocator_unit sfla_checker u_sfla_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== sim/tb_segregated_free_list_allocator_unit.sv =====
module tb_segregated_free_list_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sfla_pkg::*;

    localparam int RANDOM_ITEMS = 650;
    localparam int FILL_AFTER   = 330;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct
    {
        req_t req;
        bit   typed;
        rsp_t rsp;
    } step_t;

    typedef struct
    {
        logic [15:0] offset;
        logic [2:0]  cls;
    } held_block_t;

    logic clk;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic [15:0] class_head [CLASS_COUNT_DEF];
    logic [16:0] top_next;
    logic [15:0] link_of [LINK_DEPTH];

    rsp_t        awaited [$];
    held_block_t held [$];
    step_t       plan [$];
    rsp_t        last_rsp;

    int  errors = 0;
    int  cycles = 0;
    int  sent = 0;
    int  checked = 0;
    int  n_alloc = 0;
    int  n_trunc = 0;
    int  n_exhaust = 0;
    int  n_free = 0;
    int  n_ignored = 0;
    bit  quiet = 1'b0;
    bit  hold_wanted = 1'b0;
    bit  hold_done = 1'b0;

    segregated_free_list_allocator_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d responses outstanding.", cycles,
                     awaited.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic log_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic rsp_t serve_request(input req_t r);
        rsp_t        o;
        int          i;
        int unsigned c;
        int unsigned size;
        int unsigned slot;
        bit          oversize;
        o.block_offset = '0;
        o.block_class  = '0;
        o.status       = STS_OK;
        if (r.cmd == CMD_ALLOC)
        begin
            c = CLASS_COUNT_DEF - 1;
            for (i = CLASS_COUNT_DEF - 1; i >= 0; i--)
            begin
                if (int'(r.string_length) <= (MIN_BLOCK << i))
                    c = i;
            end
            oversize = int'(r.string_length) > (MIN_BLOCK << (CLASS_COUNT_DEF - 1));
            size = MIN_BLOCK << c;
            o.block_class = 3'(c);
            if (class_head[c] != EMPTY_MARK)
            begin
                slot = (int'(class_head[c]) >> LINK_LSB) & (LINK_DEPTH - 1);
                o.block_offset = class_head[c];
                class_head[c] = link_of[slot];
                o.status = oversize ? STS_TRUNCATED : STS_OK;
            end
            else if (int'(top_next) + ((size + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF)
                     * ALIGN_BYTES_DEF > POOL_BYTES_DEF)
            begin
                o.status = STS_EXHAUSTED;
            end
            else
            begin
                o.block_offset = top_next[15:0];
                top_next = top_next + 17'(size);
                o.status = oversize ? STS_TRUNCATED : STS_OK;
            end
        end
        else if (r.free_offset == EMPTY_MARK || int'(r.free_class) >= CLASS_COUNT_DEF)
        begin
            o.status = STS_FREE_IGN;
        end
        else
        begin
            slot = (int'(r.free_offset) >> LINK_LSB) & (LINK_DEPTH - 1);
            link_of[slot] = class_head[r.free_class];
            class_head[r.free_class] = r.free_offset;
        end
        return o;
    endfunction

    function automatic step_t row(input cmd_t c, input int len, input int off, input int cls,
                                  input bit typed, input int eoff, input int ecls,
                                  input status_t est);
        step_t s;
        s.req.cmd           = c;
        s.req.string_length = 16'(len);
        s.req.free_offset   = 16'(off);
        s.req.free_class    = 3'(cls);
        s.typed             = typed;
        s.rsp.block_offset  = 16'(eoff);
        s.rsp.block_class   = 3'(ecls);
        s.rsp.status        = est;
        return s;
    endfunction

    function automatic int unsigned pause_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic req_t alloc_for_class(input int c);
        req_t r;
        int   lo;
        lo = (c == 0) ? 1 : (MIN_BLOCK << (c - 1)) + 1;
        r.cmd           = CMD_ALLOC;
        r.string_length = 16'($urandom_range(lo, MIN_BLOCK << c));
        r.free_offset   = 16'($urandom);
        r.free_class    = 3'($urandom_range(0, 7));
        if (c == CLASS_COUNT_DEF - 1 && $urandom_range(0, 9) == 0)
            r.string_length = 16'($urandom_range((MIN_BLOCK << c) + 1, 65535));
        return r;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            r.cmd           = cmd_t'($urandom_range(0, 1));
            r.string_length = 16'($urandom_range(0, 65535));
            r.free_offset   = ($urandom_range(0, 9) == 0) ? EMPTY_MARK : 16'($urandom);
            r.free_class    = 3'($urandom_range(0, 7));
        end
        else if (pick < 55 && held.size() > 0)
        begin
            idx = $urandom_range(0, held.size() - 1);
            r.cmd           = CMD_FREE;
            r.string_length = 16'($urandom);
            r.free_offset   = held[idx].offset;
            r.free_class    = held[idx].cls;
            held.delete(idx);
        end
        else
        begin
            r = alloc_for_class($urandom_range(0, CLASS_COUNT_DEF - 1));
        end
        return r;
    endfunction

    task automatic offer(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t        got;
        held_block_t blk;
        int unsigned gap;
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        got = serve_request(r);
        awaited.push_back(typed ? typed_rsp : got);
        last_rsp = got;
        sent++;
        if (r.cmd == CMD_ALLOC)
        begin
            n_alloc++;
            if (got.status == STS_TRUNCATED)
                n_trunc++;
            if (got.status == STS_EXHAUSTED)
                n_exhaust++;
            if (got.status != STS_EXHAUSTED)
            begin
                blk.offset = got.block_offset;
                blk.cls    = got.block_class;
                held.push_back(blk);
            end
        end
        else
        begin
            n_free++;
            if (got.status == STS_FREE_IGN)
                n_ignored++;
        end
        if (sent == HOLD_AT)
            hold_wanted = 1'b1;
        gap = quiet ? 0 : pause_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_ready <= 1'b1;
                hold_done = 1'b1;
            end
            else if (quiet || $urandom_range(0, 99) < 75)
            begin
                rsp_ready <= 1'b1;
            end
            else
            begin
                rsp_ready <= 1'b0;
                repeat (1 + pause_len()) @(posedge clk);
                rsp_ready <= 1'b1;
            end
        end
    end

    // Each response beat is matched against the oldest outstanding prediction.
    always @(posedge clk)
    begin : response_check
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited.size() == 0)
            begin
                log_mismatch($sformatf("unrequested response offset=%0h class=%0d status=%0d",
                                       rsp.block_offset, rsp.block_class, rsp.status));
            end
            else
            begin
                want = awaited.pop_front();
                checked++;
                if (rsp.block_offset !== want.block_offset)
                    log_mismatch($sformatf("response %0d offset %0h, predicted %0h", checked,
                                           rsp.block_offset, want.block_offset));
                if (rsp.block_class !== want.block_class)
                    log_mismatch($sformatf("response %0d class %0d, predicted %0d", checked,
                                           rsp.block_class, want.block_class));
                if (rsp.status !== want.status)
                    log_mismatch($sformatf("response %0d status %0d, predicted %0d", checked,
                                           rsp.status, want.status));
            end
        end
    end

    initial
    begin
        int   random_sent;
        int   tries;
        int   c;
        rsp_t none;
        none = '0;
        random_sent = 0;
        foreach (class_head[k])
            class_head[k] = EMPTY_MARK;
        top_next = 17'(((ALIGN_BYTES_DEF + ALIGN_BYTES_DEF - 1) / ALIGN_BYTES_DEF)
                       * ALIGN_BYTES_DEF);

        plan.push_back(row(CMD_ALLOC, 1, 0, 0, 1'b1, 8, 0, STS_OK));
        plan.push_back(row(CMD_ALLOC, 0, 16'hFFFF, 7, 1'b1, 16, 0, STS_OK));
        plan.push_back(row(CMD_ALLOC, 8, 0, 0, 1'b1, 24, 0, STS_OK));
        plan.push_back(row(CMD_ALLOC, 9, 0, 0, 1'b1, 32, 1, STS_OK));
        plan.push_back(row(CMD_ALLOC, 256, 0, 0, 1'b1, 48, 5, STS_OK));
        plan.push_back(row(CMD_ALLOC, 257, 0, 0, 1'b1, 304, 5, STS_TRUNCATED));
        plan.push_back(row(CMD_ALLOC, 65535, 0, 0, 1'b1, 560, 5, STS_TRUNCATED));
        plan.push_back(row(CMD_ALLOC, 17, 0, 0, 1'b1, 816, 2, STS_OK));
        plan.push_back(row(CMD_ALLOC, 65, 0, 0, 1'b1, 848, 4, STS_OK));
        plan.push_back(row(CMD_ALLOC, 64, 0, 0, 1'b1, 976, 3, STS_OK));
        plan.push_back(row(CMD_FREE, 65535, 16'hFFFF, 0, 1'b1, 0, 0, STS_FREE_IGN));
        plan.push_back(row(CMD_FREE, 0, 8, 6, 1'b1, 0, 0, STS_FREE_IGN));
        plan.push_back(row(CMD_FREE, 0, 8, 7, 1'b1, 0, 0, STS_FREE_IGN));
        plan.push_back(row(CMD_FREE, 0, 8, 0, 1'b1, 0, 0, STS_OK));
        plan.push_back(row(CMD_FREE, 0, 16, 0, 1'b1, 0, 0, STS_OK));
        plan.push_back(row(CMD_ALLOC, 2, 0, 0, 1'b0, 0, 0, STS_OK));
        plan.push_back(row(CMD_ALLOC, 3, 0, 0, 1'b0, 0, 0, STS_OK));
        plan.push_back(row(CMD_FREE, 0, 16'hFFF8, 5, 1'b1, 0, 0, STS_OK));
        plan.push_back(row(CMD_ALLOC, 1000, 0, 0, 1'b0, 0, 0, STS_OK));
        plan.push_back(row(CMD_FREE, 0, 0, 3, 1'b1, 0, 0, STS_OK));
        plan.push_back(row(CMD_ALLOC, 33, 0, 0, 1'b0, 0, 0, STS_OK));
        plan.push_back(row(CMD_FREE, 0, 16'h7FFF, 4, 1'b1, 0, 0, STS_OK));
        plan.push_back(row(CMD_ALLOC, 128, 0, 0, 1'b0, 0, 0, STS_OK));
        plan.push_back(row(CMD_ALLOC, 16, 0, 0, 1'b1, 1040, 1, STS_OK));
        plan.push_back(row(CMD_ALLOC, 16'h5555, 0, 0, 1'b1, 1056, 5, STS_TRUNCATED));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            offer(plan[k].req, plan[k].typed, plan[k].rsp);

        while (random_sent < FILL_AFTER)
        begin
            if (random_sent % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            offer(random_request(), 1'b0, none);
            random_sent++;
        end

        quiet = 1'b0;
        for (c = CLASS_COUNT_DEF - 1; c >= 0; c--)
        begin
            tries = 0;
            do
            begin
                offer(alloc_for_class(c), 1'b0, none);
                random_sent++;
                tries++;
            end
            while (last_rsp.status != STS_EXHAUSTED && tries < 300);
        end

        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            offer(random_request(), 1'b0, none);
            random_sent++;
        end

        req_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d requests: %0d allocations (%0d truncated, %0d refused on a full pool),",
                 sent, n_alloc, n_trunc, n_exhaust);
        $display("%0d frees (%0d ignored); %0d responses checked, receiver hold-off %s.",
                 n_free, n_ignored, checked, hold_done ? "done" : "missed");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sfla_pkg.sv
rtl/sfla_ctrl.sv
rtl/sfla_datapath.sv
rtl/segregated_free_list_allocator_unit.sv
rtl/sfla_checker.sv
sim/tb_segregated_free_list_allocator_unit.sv
